FILE: hdl/psd3_pkg.sv
// ----------------------------------------------------------------------------
// psd3_pkg
// Types and constants shared by the point to segment distance block.
// ----------------------------------------------------------------------------
package psd3_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int FRAC_BITS   = 8;
   localparam int DIST_WIDTH  = COORD_WIDTH + FRAC_BITS + 1;

   // Intermediate widths, all sized for the extreme coordinate values.
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * COORD_WIDTH + 2;
   localparam int DOT_WIDTH   = 2 * COORD_WIDTH + 4;
   localparam int CROSS_WIDTH = 2 * COORD_WIDTH + 3;
   localparam int MAG_WIDTH   = 2 * COORD_WIDTH + 2;
   localparam int HALF_WIDTH  = COORD_WIDTH + 1;
   localparam int SQ_WIDTH    = 2 * MAG_WIDTH;
   localparam int NUM_WIDTH   = SQ_WIDTH + 2;
   localparam int DEN_WIDTH   = 2 * COORD_WIDTH + 4;
   localparam int RES_WIDTH   = NUM_WIDTH + 2 * FRAC_BITS;
   localparam int INC_WIDTH   = RES_WIDTH + 2;
   localparam int QDEN_WIDTH  = DIST_WIDTH + DEN_WIDTH;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_X = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_Y = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_Z = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_X   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_Y   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_Z   = 3'd5;

   localparam logic [1:0] REGION_START    = 2'd0;
   localparam logic [1:0] REGION_END      = 2'd1;
   localparam logic [1:0] REGION_INTERIOR = 2'd2;

   localparam int QUEUE_DEPTH       = 8;
   localparam int QUEUE_PTR_WIDTH   = 3;
   localparam int QUEUE_COUNT_WIDTH = 4;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [COORD_WIDTH-1:0] point_z;
   } req_payload_type;

   typedef struct packed {
      logic [DIST_WIDTH-1:0] distance;
      logic [1:0]            region;
   } rsp_payload_type;

   typedef struct packed {
      logic [NUM_WIDTH-1:0] num;
      logic [DEN_WIDTH-1:0] den;
      logic [1:0]           region;
   } queue_entry_type;

endpackage

FILE: hdl/psd3_front.sv
// ----------------------------------------------------------------------------
// psd3_front
// Holds the segment registers, takes query points and reduces each one to a
// region code and a squared-distance fraction num / den.
// ----------------------------------------------------------------------------
module psd3_front (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [psd3_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [psd3_pkg::COORD_WIDTH-1:0]         csr_wdata,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  psd3_pkg::req_payload_type                req_data,
   input  logic                                     queue_pop,
   output logic                                     push_valid,
   output psd3_pkg::queue_entry_type                push_data
);
   import psd3_pkg::*;

   logic signed [COORD_WIDTH-1:0] start_x_ff, start_y_ff, start_z_ff;
   logic signed [COORD_WIDTH-1:0] end_x_ff, end_y_ff, end_z_ff;

   logic [QUEUE_COUNT_WIDTH-1:0] pending_ff, pending_in;
   logic                         accept;

   logic                          s1_valid_ff;
   req_payload_type               s1_point_ff;
   logic signed [COORD_WIDTH-1:0] p [3];
   logic signed [COORD_WIDTH-1:0] s [3];
   logic signed [COORD_WIDTH-1:0] e [3];

   logic                         s2_valid_ff;
   logic signed [DIFF_WIDTH-1:0] v_ff [3];
   logic signed [DIFF_WIDTH-1:0] u_ff [3];
   logic signed [DIFF_WIDTH-1:0] d_ff [3];

   logic                         s3_valid_ff;
   logic signed [PROD_WIDTH-1:0] vv_ff [3];
   logic signed [PROD_WIDTH-1:0] dd_ff [3];
   logic signed [PROD_WIDTH-1:0] vd_ff [3];
   logic signed [PROD_WIDTH-1:0] ud_ff [3];
   logic signed [PROD_WIDTH-1:0] uu_ff [3];
   logic signed [PROD_WIDTH-1:0] ca_ff [3];
   logic signed [PROD_WIDTH-1:0] cb_ff [3];

   logic                          s4_valid_ff;
   logic signed [DOT_WIDTH-1:0]   vv_sum_ff, dd_sum_ff, vd_sum_ff, ud_sum_ff, uu_sum_ff;
   logic signed [CROSS_WIDTH-1:0] cross_ff [3];

   logic                  s5_valid_ff;
   logic [1:0]            s5_region_ff;
   logic [DEN_WIDTH-1:0]  s5_small_ff;
   logic [DEN_WIDTH-1:0]  s5_den_ff;
   logic [MAG_WIDTH-1:0]  mag_ff [3];

   logic                      s6_valid_ff;
   logic [1:0]                s6_region_ff;
   logic [DEN_WIDTH-1:0]      s6_small_ff;
   logic [DEN_WIDTH-1:0]      s6_den_ff;
   logic [2*HALF_WIDTH-1:0]   hh_ff [3];
   logic [2*HALF_WIDTH-1:0]   hl_ff [3];
   logic [2*HALF_WIDTH-1:0]   ll_ff [3];
   logic [SQ_WIDTH-1:0]       sq [3];
   logic [NUM_WIDTH-1:0]      cross2;

   function automatic logic signed [PROD_WIDTH-1:0] mul_s(
      input logic signed [DIFF_WIDTH-1:0] a,
      input logic signed [DIFF_WIDTH-1:0] b
   );
      logic signed [PROD_WIDTH-1:0] ae;
      logic signed [PROD_WIDTH-1:0] be;
      ae = PROD_WIDTH'(a);
      be = PROD_WIDTH'(b);
      return ae * be;
   endfunction

   function automatic logic signed [DOT_WIDTH-1:0] sum3(
      input logic signed [PROD_WIDTH-1:0] a,
      input logic signed [PROD_WIDTH-1:0] b,
      input logic signed [PROD_WIDTH-1:0] c
   );
      return DOT_WIDTH'(a) + DOT_WIDTH'(b) + DOT_WIDTH'(c);
   endfunction

   function automatic logic signed [DIFF_WIDTH-1:0] diff(
      input logic signed [COORD_WIDTH-1:0] a,
      input logic signed [COORD_WIDTH-1:0] b
   );
      return DIFF_WIDTH'(a) - DIFF_WIDTH'(b);
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
         start_z_ff <= '0;
         end_x_ff   <= '0;
         end_y_ff   <= '0;
         end_z_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_START_X: start_x_ff <= csr_wdata;
            CSR_START_Y: start_y_ff <= csr_wdata;
            CSR_START_Z: start_z_ff <= csr_wdata;
            CSR_END_X:   end_x_ff   <= csr_wdata;
            CSR_END_Y:   end_y_ff   <= csr_wdata;
            CSR_END_Z:   end_z_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Every item in the pipeline or the queue holds a queue slot, so the
   // pipeline never has to stall.
   assign req_ready = (pending_ff < QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
   assign accept    = req_valid && req_ready;

   always_comb begin
      case ({accept, queue_pop})
         2'b10:   pending_in = pending_ff + 1'b1;
         2'b01:   pending_in = pending_ff - 1'b1;
         default: pending_in = pending_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         pending_ff  <= pending_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_point_ff <= req_data;
      end
   end

   assign p[0] = s1_point_ff.point_x;
   assign p[1] = s1_point_ff.point_y;
   assign p[2] = s1_point_ff.point_z;
   assign s[0] = start_x_ff;
   assign s[1] = start_y_ff;
   assign s[2] = start_z_ff;
   assign e[0] = end_x_ff;
   assign e[1] = end_y_ff;
   assign e[2] = end_z_ff;

   for (genvar i = 0; i < 3; i++) begin : g_axis
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;

      always_ff @(posedge clock) begin
         v_ff[i] <= diff(p[i], s[i]);
         u_ff[i] <= diff(p[i], e[i]);
         d_ff[i] <= diff(e[i], s[i]);

         vv_ff[i] <= mul_s(v_ff[i], v_ff[i]);
         dd_ff[i] <= mul_s(d_ff[i], d_ff[i]);
         vd_ff[i] <= mul_s(v_ff[i], d_ff[i]);
         ud_ff[i] <= mul_s(u_ff[i], d_ff[i]);
         uu_ff[i] <= mul_s(u_ff[i], u_ff[i]);
         // Component i of the cross product v x d.
         ca_ff[i] <= mul_s(v_ff[J], d_ff[K]);
         cb_ff[i] <= mul_s(v_ff[K], d_ff[J]);

         cross_ff[i] <= CROSS_WIDTH'(ca_ff[i]) - CROSS_WIDTH'(cb_ff[i]);

         mag_ff[i] <= cross_ff[i][CROSS_WIDTH-1] ? MAG_WIDTH'(-cross_ff[i])
                                                 : MAG_WIDTH'(cross_ff[i]);

         // Square of the magnitude as three half-width products.
         hh_ff[i] <= mag_ff[i][MAG_WIDTH-1:HALF_WIDTH] * mag_ff[i][MAG_WIDTH-1:HALF_WIDTH];
         hl_ff[i] <= mag_ff[i][MAG_WIDTH-1:HALF_WIDTH] * mag_ff[i][HALF_WIDTH-1:0];
         ll_ff[i] <= mag_ff[i][HALF_WIDTH-1:0] * mag_ff[i][HALF_WIDTH-1:0];
      end

      assign sq[i] = (SQ_WIDTH'(hh_ff[i]) << (2 * HALF_WIDTH))
                   + (SQ_WIDTH'(hl_ff[i]) << (HALF_WIDTH + 1))
                   + SQ_WIDTH'(ll_ff[i]);
   end

   always_ff @(posedge clock) begin
      vv_sum_ff <= sum3(vv_ff[0], vv_ff[1], vv_ff[2]);
      dd_sum_ff <= sum3(dd_ff[0], dd_ff[1], dd_ff[2]);
      vd_sum_ff <= sum3(vd_ff[0], vd_ff[1], vd_ff[2]);
      ud_sum_ff <= sum3(ud_ff[0], ud_ff[1], ud_ff[2]);
      uu_sum_ff <= sum3(uu_ff[0], uu_ff[1], uu_ff[2]);
   end

   // Exact sign tests pick the region. Past the end means (P-E).(S-E) < 0,
   // which is the same as (P-E).d > 0.
   always_ff @(posedge clock) begin
      s5_den_ff <= DEN_WIDTH'(dd_sum_ff);
      if (dd_sum_ff == '0 || vd_sum_ff[DOT_WIDTH-1]) begin
         s5_region_ff <= REGION_START;
         s5_small_ff  <= DEN_WIDTH'(vv_sum_ff);
      end else if (!ud_sum_ff[DOT_WIDTH-1] && ud_sum_ff != '0) begin
         s5_region_ff <= REGION_END;
         s5_small_ff  <= DEN_WIDTH'(uu_sum_ff);
      end else begin
         s5_region_ff <= REGION_INTERIOR;
         s5_small_ff  <= DEN_WIDTH'(vv_sum_ff);
      end
      s6_region_ff <= s5_region_ff;
      s6_small_ff  <= s5_small_ff;
      s6_den_ff    <= s5_den_ff;
   end

   assign cross2 = NUM_WIDTH'(sq[0]) + NUM_WIDTH'(sq[1]) + NUM_WIDTH'(sq[2]);

   assign push_valid       = s6_valid_ff;
   assign push_data.region = s6_region_ff;
   assign push_data.num    = (s6_region_ff == REGION_INTERIOR) ? cross2
                                                               : NUM_WIDTH'(s6_small_ff);
   assign push_data.den    = (s6_region_ff == REGION_INTERIOR) ? s6_den_ff
                                                               : DEN_WIDTH'(1);

endmodule

FILE: hdl/psd3_queue.sv
// ----------------------------------------------------------------------------
// psd3_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module psd3_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  psd3_pkg::queue_entry_type  push_data,
   input  logic                       pop,
   output logic                       head_valid,
   output psd3_pkg::queue_entry_type  head_data
);
   import psd3_pkg::*;

   queue_entry_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff;

   // The front never pushes into a full queue: its slot count covers it.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push_valid, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

endmodule

FILE: hdl/psd3_back.sv
// ----------------------------------------------------------------------------
// psd3_back
// Pipelined fixed-point root of num / den, one result bit per stage.
// ----------------------------------------------------------------------------
module psd3_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       head_valid,
   input  psd3_pkg::queue_entry_type  head_data,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output psd3_pkg::rsp_payload_type  rsp_data
);
   import psd3_pkg::*;

   // Each stage holds the residual R = num * 4^FRAC_BITS - q^2 * den and
   // T = q * den. Setting bit b of q costs den * (2^(b+1) * q + 4^b).
   logic                   valid_ff  [DIST_WIDTH];
   logic [RES_WIDTH-1:0]   res_ff    [DIST_WIDTH];
   logic [QDEN_WIDTH-1:0]  qden_ff   [DIST_WIDTH];
   logic [DIST_WIDTH-1:0]  q_ff      [DIST_WIDTH];
   logic [DEN_WIDTH-1:0]   den_ff    [DIST_WIDTH];
   logic [1:0]             region_ff [DIST_WIDTH];

   logic [RES_WIDTH-1:0]   res_in  [DIST_WIDTH];
   logic [QDEN_WIDTH-1:0]  qden_in [DIST_WIDTH];
   logic [DIST_WIDTH-1:0]  q_in    [DIST_WIDTH];

   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;
   logic            advance;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign pop     = advance && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff[0]    <= RES_WIDTH'(head_data.num) << (2 * FRAC_BITS);
         qden_ff[0]   <= '0;
         q_ff[0]      <= '0;
         den_ff[0]    <= head_data.den;
         region_ff[0] <= head_data.region;
      end
   end

   for (genvar k = 0; k < DIST_WIDTH; k++) begin : g_step
      localparam int B = DIST_WIDTH - 1 - k;
      logic [INC_WIDTH-1:0] inc;
      logic                 take;

      assign inc  = (INC_WIDTH'(qden_ff[k]) << (B + 1))
                  + (INC_WIDTH'(den_ff[k]) << (2 * B));
      assign take = (INC_WIDTH'(res_ff[k]) >= inc);

      assign res_in[k]  = take ? RES_WIDTH'(INC_WIDTH'(res_ff[k]) - inc) : res_ff[k];
      assign qden_in[k] = take ? qden_ff[k] + (QDEN_WIDTH'(den_ff[k]) << B) : qden_ff[k];
      assign q_in[k]    = take ? (q_ff[k] | (DIST_WIDTH'(1) << B)) : q_ff[k];

      if (k < DIST_WIDTH - 1) begin : g_reg
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k+1] <= 1'b0;
            end else if (advance) begin
               valid_ff[k+1] <= valid_ff[k];
            end
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               res_ff[k+1]    <= res_in[k];
               qden_ff[k+1]   <= qden_in[k];
               q_ff[k+1]      <= q_in[k];
               den_ff[k+1]    <= den_ff[k];
               region_ff[k+1] <= region_ff[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid_ff[DIST_WIDTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff.distance <= q_in[DIST_WIDTH-1];
         rsp_data_ff.region   <= region_ff[DIST_WIDTH-1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hdl/point_segment_distance_3d.sv
// ----------------------------------------------------------------------------
// point_segment_distance_3d
// Distance from a stream of 3D query points to a configured segment.
// ----------------------------------------------------------------------------
// The block takes one query point per cycle while responses are taken and
// returns one result per point in order: the distance to the segment with 8
// fraction bits, truncated, and a region code. The path runs through six front
// stages of differences, products, sums and the region decision, the queue,
// 25 root stages (one result bit each) and the output register. The root
// pipeline sets the depth; throughput stays at one item per cycle while
// responses are taken. Segment registers must be written through the csr_
// port only while no point is in flight; the block does not enforce this.
module point_segment_distance_3d (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [psd3_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [psd3_pkg::COORD_WIDTH-1:0]      csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  psd3_pkg::req_payload_type             req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output psd3_pkg::rsp_payload_type             rsp_data
);
   import psd3_pkg::*;

   logic            push_valid;
   queue_entry_type push_data;
   logic            head_valid;
   queue_entry_type head_data;
   logic            pop;

   psd3_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_pop  (pop),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   psd3_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   psd3_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: hdl/psd3_checker.sv
// ----------------------------------------------------------------------------
// psd3_checker
// Port-level checks on the response side of the distance block.
// ----------------------------------------------------------------------------
module psd3_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  psd3_pkg::rsp_payload_type  rsp_data
);
   import psd3_pkg::*;

   a_region_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.region == REGION_START ||
                     rsp_data.region == REGION_END ||
                     rsp_data.region == REGION_INTERIOR))
      else $error("response carries an unused region code");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response transfer changed");

endmodule

bind point_segment_distance_3d psd3_checker u_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for point_segment_distance_3d.
// ----------------------------------------------------------------------------
// Query points are driven into the block while a scoreboard predicts each
// distance and region exactly in wide integer arithmetic. Results are
// compared in order. The segment registers are rewritten from time to time,
// always while the pipeline is empty. Sender and receiver stall at random, and the
// receiver also holds off for long stretches so that the block back-pressures.
// ----------------------------------------------------------------------------
module tb;
   import psd3_pkg::*;

   typedef logic signed [COORD_WIDTH-1:0] coord_t;
   typedef longint vec_t [3];

   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 400000;

   class distance_scoreboard;
      coord_t          seg_reg [6];
      rsp_payload_type expected_q [$];
      int              errors;

      function new();
         foreach (seg_reg[i]) seg_reg[i] = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, coord_t val);
         if (idx <= CSR_END_Z) seg_reg[idx] = val;
      endfunction

      function longint dot(vec_t a, vec_t b);
         return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
      endfunction

      // Largest q with q^2 * den <= num * 2^(2*FRAC_BITS).
      function logic [DIST_WIDTH-1:0] root(logic [127:0] num, logic [127:0] den);
         logic [127:0] lim;
         logic [127:0] q;
         logic [127:0] c;
         lim = num << (2 * FRAC_BITS);
         q = '0;
         for (int b = DIST_WIDTH - 1; b >= 0; b--) begin
            c = q | (128'd1 << b);
            if (c * c * den <= lim) q = c;
         end
         return q[DIST_WIDTH-1:0];
      endfunction

      function rsp_payload_type predict_distance(req_payload_type pt);
         vec_t s, e, p, d, v, u, f;
         longint dd, vv, uu, vd, mag_vd;
         logic [127:0] num;
         rsp_payload_type r;
         p[0] = pt.point_x; p[1] = pt.point_y; p[2] = pt.point_z;
         for (int i = 0; i < 3; i++) begin
            s[i] = seg_reg[CSR_START_X + i];
            e[i] = seg_reg[CSR_END_X + i];
            d[i] = e[i] - s[i];
            v[i] = p[i] - s[i];
            u[i] = p[i] - e[i];
            f[i] = s[i] - e[i];
         end
         dd = dot(d, d);
         vv = dot(v, v);
         vd = dot(v, d);
         if (dd == 0 || vd < 0) begin
            r.region   = REGION_START;
            r.distance = root(128'(vv), 128'd1);
         end else if (dot(u, f) < 0) begin
            uu = dot(u, u);
            r.region   = REGION_END;
            r.distance = root(128'(uu), 128'd1);
         end else begin
            mag_vd = vd;
            num = 128'(vv) * 128'(dd) - 128'(mag_vd) * 128'(mag_vd);
            r.region   = REGION_INTERIOR;
            r.distance = root(num, 128'(dd));
         end
         return r;
      endfunction

      function void note_point(req_payload_type pt);
         expected_q.push_back(predict_distance(pt));
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type exp_r;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result distance=%0d region=%0d",
                     $time, got.distance, got.region);
            errors++;
            return;
         end
         exp_r = expected_q.pop_front();
         if (got.distance !== exp_r.distance) begin
            $display("%0t: distance mismatch expected=%0d actual=%0d",
                     $time, exp_r.distance, got.distance);
            errors++;
         end
         if (got.region !== exp_r.region) begin
            $display("%0t: region mismatch expected=%0d actual=%0d",
                     $time, exp_r.region, got.region);
            errors++;
         end
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index = '0;
   logic [COORD_WIDTH-1:0]      csr_wdata = '0;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   req_payload_type             req_data = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   rsp_payload_type             rsp_data;

   distance_scoreboard sb = new();
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  hold_cycles   = 0;
   int  cycle_count   = 0;

   point_segment_distance_3d i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Observe every transfer at the rising edge.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, coord_t'(csr_wdata));
         if (req_valid && req_ready) sb.note_point(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Receiver: random stalls, or a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Leaves csr_valid high; the caller drops it after the last write.
   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] idx, coord_t val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic send_point(coord_t x, coord_t y, coord_t z);
      req_payload_type pt;
      pt.point_x = x; pt.point_y = y; pt.point_z = z;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= pt;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_segment(coord_t sx, coord_t sy, coord_t sz,
                              coord_t ex, coord_t ey, coord_t ez);
      wait_drained();
      write_csr(CSR_START_X, sx);
      write_csr(CSR_START_Y, sy);
      write_csr(CSR_START_Z, sz);
      write_csr(CSR_END_X, ex);
      write_csr(CSR_END_Y, ey);
      write_csr(CSR_END_Z, ez);
      csr_valid <= 1'b0;
   endtask

   function automatic coord_t clamp(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return coord_t'(v);
   endfunction

   function automatic coord_t rand_coord();
      return coord_t'($urandom);
   endfunction

   task automatic random_segment();
      coord_t s [3];
      coord_t e [3];
      int kind;
      kind = $urandom_range(9);
      for (int i = 0; i < 3; i++) begin
         s[i] = rand_coord();
         case (kind)
            0:       e[i] = s[i];
            1:       e[i] = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            2, 3:    e[i] = clamp(longint'(s[i]) + longint'($urandom_range(40)) - 20);
            default: e[i] = rand_coord();
         endcase
      end
      set_segment(s[0], s[1], s[2], e[0], e[1], e[2]);
   endtask

   // Mostly points near the segment line, some anywhere.
   task automatic random_point();
      longint t;
      coord_t c [3];
      t = longint'($urandom_range(1200)) - 100;
      for (int i = 0; i < 3; i++) begin
         if ($urandom_range(3) == 0)
            c[i] = rand_coord();
         else
            c[i] = clamp(longint'(sb.seg_reg[CSR_START_X + i]) +
                         (longint'(sb.seg_reg[CSR_END_X + i]) -
                          longint'(sb.seg_reg[CSR_START_X + i])) * t / 1000 +
                         longint'($urandom_range(64)) - 32);
      end
      send_point(c[0], c[1], c[2]);
   endtask

   task automatic random_phase(int sender_pct, int receiver_pct, int count);
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      for (int n = 0; n < count; n++) begin
         if (n % 60 == 0) random_segment();
         random_point();
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Degenerate segment straight after reset, then extremes of every field.
      send_point(16'sh0000, 16'sh0000, 16'sh0000);
      send_point(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_point(16'sh8000, 16'sh8000, 16'sh8000);
      send_point(16'sh8000, 16'sh7fff, 16'sh0001);
      set_segment(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_point(16'sh7fff, 16'sh8000, 16'sh7fff);
      send_point(16'sh8000, 16'sh7fff, 16'sh8000);
      send_point(16'sh0000, 16'sh0000, 16'sh0000);
      send_point(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_point(16'sh8000, 16'sh8000, 16'sh8000);
      set_segment(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0064, 16'sh0000, 16'sh0000);
      send_point(-16'sd10, 16'sd3, 16'sd4);   // before the start
      send_point(16'sd110, 16'sd3, 16'sd4);   // past the end
      send_point(16'sd50, 16'sd3, 16'sd4);    // interior
      send_point(16'sd30, 16'sd0, 16'sd0);    // on the segment
      send_point(16'sd100, 16'sd7, 16'sd1);   // projection exactly on the end
      send_point(16'sd0, -16'sd5, 16'sd2);    // projection exactly on the start
      send_point(16'sd50, 16'sd1, 16'sd1);    // fractional result
      set_segment(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
      send_point(16'sh0000, 16'sh0000, 16'sh0000);
      send_point(16'sh7fff, 16'sh7fff, 16'sh8000);
      send_point(16'sh8000, 16'sh8000, 16'sh7fff);

      random_phase(9, 52, 260);
      random_phase(52, 9, 260);
      random_phase(0, 0, 220);

      // Long receiver hold-off while points keep coming, so the block fills.
      hold_cycles = 150;
      for (int n = 0; n < 40; n++) random_point();
      wait_drained();

      if (sb.errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
